/* rtl/aircon_remote_state_tracker_defines.svh */
// Assertion macros used by the tracker's RTL.
`ifndef AIRCON_REMOTE_STATE_TRACKER_DEFINES_SVH
`define AIRCON_REMOTE_STATE_TRACKER_DEFINES_SVH

`define ACRST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ACRST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/acrst_pkg.sv */
package acrst_pkg;

	typedef enum logic [3:0] {
		CMD_TICK   = 4'd0,
		CMD_POWER  = 4'd1,
		CMD_TIMER  = 4'd2,
		CMD_UP     = 4'd3,
		CMD_DOWN   = 4'd4,
		CMD_MODE   = 4'd5,
		CMD_FAN    = 4'd6,
		CMD_SILENT = 4'd7,
		CMD_ECO    = 4'd8,
		CMD_FLAP   = 4'd9,
		CMD_LOAD   = 4'd10
	} cmd_t;

	localparam logic [1:0] MODE_COOL = 2'd0;
	localparam logic [1:0] MODE_DRY  = 2'd1;
	localparam logic [1:0] MODE_FAN  = 2'd2;

	localparam logic [1:0] FAN_MIN  = 2'd0;
	localparam logic [1:0] FAN_MED  = 2'd1;
	localparam logic [1:0] FAN_MAX  = 2'd2;
	localparam logic [1:0] FAN_AUTO = 2'd3;

	localparam logic [1:0] TMR_OFF  = 2'd0;
	localparam logic [1:0] TMR_EDIT = 2'd1;
	localparam logic [1:0] TMR_RUN  = 2'd2;

	localparam logic [5:0] STEP_KNEE_HALFH = 6'd20;

	localparam logic [2:0] REG_TEMP_MIN    = 3'd0;
	localparam logic [2:0] REG_TEMP_MAX    = 3'd1;
	localparam logic [2:0] REG_TIMER_MIN   = 3'd2;
	localparam logic [2:0] REG_TIMER_MAX   = 3'd3;
	localparam logic [2:0] REG_EDIT_WINDOW = 3'd4;

	localparam int CHANGED_BIT = 22;

	typedef struct packed {
		logic       power_on;
		logic [1:0] mode;
		logic [5:0] set_temp;
		logic [1:0] fan;
		logic       silent;
		logic       eco;
		logic       swing;
		logic [1:0] tmr_state;
		logic [5:0] tmr_len;
	} panel_t;

	typedef struct packed {
		logic [5:0]  temp_min;
		logic [5:0]  temp_max;
		logic [5:0]  tmr_len_lo;
		logic [5:0]  tmr_len_hi;
		logic [15:0] edit_window_ticks;
	} cfg_t;

endpackage

/* rtl/aircon_remote_state_tracker.sv */
// Shadows the panel state of an air conditioner from a stream of panel events.
// The slave channel takes one event word per cycle: s_tuser carries the command
// (tick, button or load) and s_tdata the values that a load writes. For every
// event the master channel returns one word with the whole panel state after
// the event and a flag that tells whether anything changed or a load came.
// An event is captured in an input register, worked through combinationally
// and placed in the output register. One event is taken every cycle while
// m_tready is high. When the receiver stalls, the output register holds its
// word and the input register takes one more event; s_tready then falls until
// the output drains. The configuration port writes the setpoint and timer
// bounds and the edit window; writes take effect at once. The user must write
// only while no event is in flight; the block does not enforce this. Reset
// sets power off, cool mode, 24 degrees, auto fan, flags clear, timer off at
// one hour, and the default bounds; no event is lost or repeated on a stall.
`include "aircon_remote_state_tracker_defines.svh"

module aircon_remote_state_tracker #(
	parameter int WINDOW_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// load_on, load_mode, load_temp, load_fan, load_silent, load_eco, load_swing,
	// load_tmr_state, load_tmr_len, then two unused bits.
	input  logic [23:0] s_tdata,
	// cmd.
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// power_on, mode, set_temp, fan, silent, eco, swing, tmr_state,
	// tmr_len, changed, then one zero bit.
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import acrst_pkg::*;

	logic                   valid_s1;
	logic [3:0]             cmd_s1;
	panel_t                 load_s1;
	logic                   m_valid_q;
	logic [23:0]            m_data_q;
	panel_t                 state_q;
	logic [WINDOW_BITS-1:0] cnt_q;
	cfg_t                   cfg_q;
	panel_t                 nxt;
	logic [WINDOW_BITS-1:0] cnt_nxt;
	logic                   changed;
	logic                   advance;
	logic                   take;

	assign advance  = !m_valid_q || m_tready;
	assign take     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	acrst_step #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.cnt    (cnt_q),
		.cmd    (cmd_s1),
		.ld     (load_s1),
		.nxt    (nxt),
		.cnt_nxt(cnt_nxt),
		.changed(changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1              <= s_tuser;
			load_s1.power_on    <= s_tdata[0];
			load_s1.mode        <= s_tdata[2:1];
			load_s1.set_temp    <= s_tdata[8:3];
			load_s1.fan         <= s_tdata[10:9];
			load_s1.silent      <= s_tdata[11];
			load_s1.eco         <= s_tdata[12];
			load_s1.swing       <= s_tdata[13];
			load_s1.tmr_state   <= s_tdata[15:14];
			load_s1.tmr_len     <= s_tdata[21:16];
		end
		if (take) begin
			m_data_q <= {1'b0, changed, nxt.tmr_len, nxt.tmr_state, nxt.swing, nxt.eco,
				nxt.silent, nxt.fan, nxt.set_temp, nxt.mode, nxt.power_on};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.power_on  <= 1'b0;
			state_q.mode      <= MODE_COOL;
			state_q.set_temp  <= 6'd24;
			state_q.fan       <= FAN_AUTO;
			state_q.silent    <= 1'b0;
			state_q.eco       <= 1'b0;
			state_q.swing     <= 1'b0;
			state_q.tmr_state <= TMR_OFF;
			state_q.tmr_len   <= 6'd2;
			cnt_q             <= '0;
		end else if (take) begin
			state_q <= nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_min          <= 6'd16;
			cfg_q.temp_max          <= 6'd30;
			cfg_q.tmr_len_lo        <= 6'd1;
			cfg_q.tmr_len_hi        <= 6'd48;
			cfg_q.edit_window_ticks <= 16'd4000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TEMP_MIN:    cfg_q.temp_min          <= cfg_wdata[5:0];
				REG_TEMP_MAX:    cfg_q.temp_max          <= cfg_wdata[5:0];
				REG_TIMER_MIN:   cfg_q.tmr_len_lo        <= cfg_wdata[5:0];
				REG_TIMER_MAX:   cfg_q.tmr_len_hi        <= cfg_wdata[5:0];
				REG_EDIT_WINDOW: cfg_q.edit_window_ticks <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	`ACRST_ASSERT_NEXT(a_load_changed, take && cmd_s1 == CMD_LOAD, m_tdata[CHANGED_BIT], "load word not flagged as changed")
	`ACRST_ASSERT_NEXT(a_take_shows, take, m_tvalid, "finished word did not reach the output")
	`ACRST_ASSERT_NOW(a_dry_fan_auto, m_tvalid && m_tdata[2:1] == MODE_DRY, m_tdata[10:9] == FAN_AUTO, "dry mode word without auto fan")

endmodule

/* rtl/acrst_step.sv */
module acrst_step #(
	parameter int WINDOW_BITS = 16
) (
	input  acrst_pkg::cfg_t           cfg,
	input  acrst_pkg::panel_t         cur,
	input  logic [WINDOW_BITS-1:0]    cnt,
	input  logic [3:0]                cmd,
	input  acrst_pkg::panel_t         ld,
	output acrst_pkg::panel_t         nxt,
	output logic [WINDOW_BITS-1:0]    cnt_nxt,
	output logic                      changed
);
	import acrst_pkg::*;

	localparam logic [31:0] WIN_MAX = 32'((64'd1 << WINDOW_BITS) - 64'd1);

	function automatic logic [5:0] clamp8(logic signed [7:0] v, logic [5:0] lo,
			logic [5:0] hi);
		logic signed [7:0] r;
		r = v;
		if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
		if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
		return r[5:0];
	endfunction

	logic [31:0]            win32;
	logic [WINDOW_BITS-1:0] arm_val;
	logic signed [7:0]      h_up;
	logic signed [7:0]      h_dn;
	logic signed [7:0]      t_step;
	logic                   is_load;
	logic                   editing;
	panel_t                 s;

	assign win32   = {16'd0, cfg.edit_window_ticks};
	assign arm_val = (win32 > WIN_MAX) ? WIN_MAX[WINDOW_BITS-1:0] : win32[WINDOW_BITS-1:0];
	assign is_load = (cmd == CMD_LOAD);

	assign h_up = $signed({2'b00, cur.tmr_len})
		+ ((cur.tmr_len < STEP_KNEE_HALFH) ? 8'sd1 : 8'sd2);
	assign h_dn = $signed({2'b00, cur.tmr_len})
		- ((cur.tmr_len > STEP_KNEE_HALFH) ? 8'sd2 : 8'sd1);
	assign t_step = $signed({2'b00, cur.set_temp}) + ((cmd == CMD_UP) ? 8'sd1 : -8'sd1);

	always_comb begin
		s       = cur;
		cnt_nxt = cnt;
		editing = 1'b0;
		if (is_load) begin
			s = ld;
			if (ld.mode == 2'd3) s.mode = MODE_COOL;
			if (ld.tmr_state == 2'd3) s.tmr_state = TMR_OFF;
		end else begin
			if (cmd == CMD_TICK && cnt != '0) cnt_nxt = cnt - WINDOW_BITS'(1);
			if (s.tmr_state == TMR_EDIT && cnt_nxt == '0) s.tmr_state = TMR_RUN;
			editing = (s.tmr_state == TMR_EDIT);
			if (cmd == CMD_POWER) begin
				s.power_on = ~s.power_on;
			end else if (cmd == CMD_TIMER) begin
				if (editing) begin
					s.tmr_state = TMR_OFF;
				end else begin
					s.tmr_state = TMR_EDIT;
					cnt_nxt     = arm_val;
				end
			end else if (editing && (cmd == CMD_UP || cmd == CMD_DOWN)) begin
				s.tmr_len = clamp8((cmd == CMD_UP) ? h_up : h_dn,
					cfg.tmr_len_lo, cfg.tmr_len_hi);
				cnt_nxt = arm_val;
			end else if (!s.power_on) begin
				s = s;
			end else if (cmd == CMD_MODE) begin
				case (s.mode)
					MODE_COOL: s.mode = MODE_DRY;
					MODE_DRY:  s.mode = MODE_FAN;
					default:   s.mode = MODE_COOL;
				endcase
			end else if (cmd == CMD_UP || cmd == CMD_DOWN) begin
				if (s.mode == MODE_COOL && t_step >= $signed({2'b00, cfg.temp_min})
						&& t_step <= $signed({2'b00, cfg.temp_max})) begin
					s.set_temp = t_step[5:0];
				end
			end else if (cmd == CMD_FAN) begin
				if (s.mode == MODE_COOL) begin
					s.fan = s.fan + 2'd1;
				end else if (s.mode == MODE_FAN) begin
					case (s.fan)
						FAN_MIN: s.fan = FAN_MED;
						FAN_MED: s.fan = FAN_MAX;
						FAN_MAX: s.fan = FAN_MIN;
						default: s.fan = FAN_MED;
					endcase
				end
			end else if (cmd == CMD_SILENT) begin
				if (s.mode == MODE_COOL) s.silent = ~s.silent;
			end else if (cmd == CMD_ECO) begin
				if (s.mode == MODE_COOL) s.eco = ~s.eco;
			end else if (cmd == CMD_FLAP) begin
				s.swing = ~s.swing;
			end
		end

		nxt = s;
		if (nxt.set_temp < cfg.temp_min) nxt.set_temp = cfg.temp_min;
		if (nxt.set_temp > cfg.temp_max) nxt.set_temp = cfg.temp_max;
		if (nxt.tmr_len < cfg.tmr_len_lo) nxt.tmr_len = cfg.tmr_len_lo;
		if (nxt.tmr_len > cfg.tmr_len_hi) nxt.tmr_len = cfg.tmr_len_hi;
		if (nxt.mode != MODE_COOL) begin
			nxt.silent = 1'b0;
			nxt.eco    = 1'b0;
		end
		if (nxt.mode == MODE_DRY) nxt.fan = FAN_AUTO;
		if (nxt.mode == MODE_FAN && nxt.fan == FAN_AUTO) nxt.fan = FAN_MAX;
	end

	assign changed = is_load || (nxt != cur);

endmodule
